// ----- rtl/core/bounded_channel_with_waiters_unit_macros.svh -----
// assertion macros for the channel unit
`ifndef BOUNDED_CHANNEL_WITH_WAITERS_UNIT_MACROS_SVH
`define BOUNDED_CHANNEL_WITH_WAITERS_UNIT_MACROS_SVH
// implication checked every clock outside reset
`define BCW_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
// next-cycle implication
`define BCW_ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ----- rtl/core/bcw_pkg.sv -----
package bcw_pkg;
  localparam int MsgDepth = 16;
  localparam int WaiterDepth = 8;
  localparam int MsgAw = $clog2(MsgDepth);
  localparam int WaitAw = $clog2(WaiterDepth);
  localparam int QDepth = 2;

  typedef enum logic [2:0] {
    OP_SEND = 3'd0, OP_RECV = 3'd1, OP_PARK_S = 3'd2, OP_PARK_R = 3'd3, OP_CLOSE = 3'd4
  } op_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [63:0] message;
    logic [23:0] tag;
  } cmd_t;

  typedef struct packed {
    logic        ok;
    logic [63:0] message_out;
    logic        wake_valid;
    logic [7:0]  wake_vm;
    logic [15:0] wake_handle;
    logic        wake_has_value;
    logic [63:0] wake_value;
    logic        closed_flag;
    logic        overflow;
  } res_t;

  typedef enum logic [0:0] {BS_IDLE = 1'b0, BS_FULL = 1'b1} bs_t;
endpackage

// ----- rtl/core/bounded_channel_with_waiters_unit.sv -----
// channel   dir  handshake              payload
// s_axis    in   s_tvalid / s_tready    operation, message, waiter_vm, waiter_handle
// m_axis    out  m_tvalid / m_tready    ok .. overflow (see m_tdata)
// apb       in   psel/penable/pready    capacity at address 0
//
// one operation per cycle sustained while m_tready holds; an operation passes from
// input transfer to result through the front queue, then the back result register
// reset is synchronous, rst high clears pointers, counts, closed and queue
// a stalled result register holds the back; the two-entry front queue keeps
// accepting until full
`include "bounded_channel_with_waiters_unit_macros.svh"
module bounded_channel_with_waiters_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // operation[2:0], message[66:3], waiter_vm[74:67], waiter_handle[90:75], zero fill
  input  logic [95:0]  s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // ok[0], message_out[64:1], wake_valid[65], wake_vm[73:66], wake_handle[89:74],
  // wake_has_value[90], wake_value[154:91], closed_flag[155], overflow[156], zero fill
  output logic [159:0] m_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import bcw_pkg::*;
  localparam logic [2:0] AddrCapacity = 3'd0;

  logic [4:0] capacity;
  logic q_valid, q_ready;
  cmd_t q_cmd;
  res_t res;

  assign pready = 1'b1;
  assign prdata = (paddr == AddrCapacity) ? {27'd0, capacity} : 32'd0;

  // capacity register, to be written only while idle; the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) capacity <= '0;
    else if (psel && penable && pwrite && paddr == AddrCapacity) capacity <= pwdata[4:0];
  end

  // front: accepts and queues operations
  bcw_front u_front (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata,
    .q_valid, .q_ready, .q_cmd
  );

  // back: channel state, buffer and waiter fifos
  bcw_back u_back (
    .clk, .rst, .capacity, .q_valid, .q_ready, .q_cmd,
    .m_tvalid, .m_tready, .m_res(res)
  );

  assign m_tdata = {3'd0, res.overflow, res.closed_flag, res.wake_value, res.wake_has_value,
                    res.wake_handle, res.wake_vm, res.wake_valid, res.message_out, res.ok};

  `BCW_ASSERT_IMP(a_wake_value_only_with_flag, clk, rst,
    m_tvalid && !m_tdata[90], m_tdata[154:91] == 64'd0)
  `BCW_ASSERT_NXT(a_stalled_result_holds, clk, rst,
    m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `BCW_ASSERT_IMP(a_overflow_not_ok, clk, rst, m_tvalid && m_tdata[156], !m_tdata[0])
endmodule

// ----- rtl/core/bcw_front.sv -----
module bcw_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [95:0]     s_tdata,
  output logic            q_valid,
  input  logic            q_ready,
  output bcw_pkg::cmd_t   q_cmd
);
  import bcw_pkg::*;
  localparam int Qw = $clog2(QDepth);
  cmd_t        qmem [QDepth];
  logic [Qw-1:0] wp, rp;
  logic [Qw:0] cnt;
  logic        push, pop;
  cmd_t        c;

  // decode the packed input into a command
  always_comb begin
    c.op = s_tdata[2:0];
    c.message = s_tdata[66:3];
    c.tag = {s_tdata[74:67], s_tdata[90:75]};
  end

  assign s_tready = (cnt != (Qw+1)'(QDepth));
  assign push = s_tvalid && s_tready;
  assign q_valid = (cnt != '0);
  assign pop = q_valid && q_ready;
  assign q_cmd = qmem[rp];

  always_ff @(posedge clk) begin
    if (push) qmem[wp] <= c;
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      cnt <= cnt + (Qw+1)'(push) - (Qw+1)'(pop);
    end
  end
endmodule

// ----- rtl/core/bcw_back.sv -----
module bcw_back (
  input  logic           clk,
  input  logic           rst,
  input  logic [4:0]     capacity,
  input  logic           q_valid,
  output logic           q_ready,
  input  bcw_pkg::cmd_t  q_cmd,
  output logic           m_tvalid,
  input  logic           m_tready,
  output bcw_pkg::res_t  m_res
);
  import bcw_pkg::*;
  logic [63:0] slots [MsgDepth];
  logic [23:0] stags [WaiterDepth];
  logic [63:0] svals [WaiterDepth];
  logic [23:0] rtags [WaiterDepth];
  logic [MsgAw-1:0] rdp, wrp;
  logic [MsgAw:0] scnt;
  logic closed;
  logic [WaitAw-1:0] sh, st, rh, rt;
  logic [WaitAw:0] sc, rc;
  bs_t state;

  logic [MsgAw:0] cap;
  logic go;
  res_t r;
  logic do_wr, do_rd, s_pop, s_push, r_pop, r_push;
  logic [63:0] wr_data;

  function automatic logic [MsgAw-1:0] rnext(logic [MsgAw-1:0] p, logic [MsgAw:0] cp);
    logic [MsgAw:0] n;
    n = {1'b0, p} + 1'b1;
    return (n >= cp) ? '0 : n[MsgAw-1:0];
  endfunction
  function automatic logic [WaitAw-1:0] wnext(logic [WaitAw-1:0] p);
    logic [WaitAw:0] n;
    n = {1'b0, p} + 1'b1;
    return (n >= (WaitAw+1)'(WaiterDepth)) ? '0 : n[WaitAw-1:0];
  endfunction

  assign cap = (capacity > 5'(MsgDepth)) ? (MsgAw+1)'(MsgDepth) : (MsgAw+1)'(capacity);
  assign q_ready = (state == BS_IDLE) || m_tready;
  assign go = q_valid && q_ready;
  assign m_tvalid = (state == BS_FULL);

  always_comb begin
    r = '0;
    do_wr = 1'b0; do_rd = 1'b0; s_pop = 1'b0; s_push = 1'b0;
    r_pop = 1'b0; r_push = 1'b0; wr_data = q_cmd.message;
    case (q_cmd.op)
      OP_SEND: if (!closed) begin
        if (rc != '0) begin
          r_pop = 1'b1; r.ok = 1'b1; r.wake_valid = 1'b1;
          {r.wake_vm, r.wake_handle} = rtags[rh];
          r.wake_has_value = 1'b1; r.wake_value = q_cmd.message;
        end else if (cap != '0 && scnt < cap) begin
          do_wr = 1'b1; r.ok = 1'b1;
        end
      end
      OP_RECV: begin
        if (scnt != '0) begin
          do_rd = 1'b1; r.ok = 1'b1; r.message_out = slots[rdp];
          if (cap != '0 && sc != '0) begin
            s_pop = 1'b1; do_wr = 1'b1; wr_data = svals[sh];
            r.wake_valid = 1'b1; {r.wake_vm, r.wake_handle} = stags[sh];
          end
        end else if (sc != '0) begin
          s_pop = 1'b1; r.ok = 1'b1; r.message_out = svals[sh];
          r.wake_valid = 1'b1; {r.wake_vm, r.wake_handle} = stags[sh];
        end
      end
      OP_PARK_S: if (sc == (WaitAw+1)'(WaiterDepth)) r.overflow = 1'b1; else s_push = 1'b1;
      OP_PARK_R: if (rc == (WaitAw+1)'(WaiterDepth)) r.overflow = 1'b1; else r_push = 1'b1;
      default: ;
    endcase
    r.closed_flag = closed || (q_cmd.op == OP_CLOSE);
  end

  always_ff @(posedge clk) begin
    if (go) begin
      m_res <= r;
      if (do_wr) slots[wrp] <= wr_data;
      if (s_push) begin stags[st] <= q_cmd.tag; svals[st] <= q_cmd.message; end
      if (r_push) rtags[rt] <= q_cmd.tag;
    end
    if (rst) begin
      state <= BS_IDLE; rdp <= '0; wrp <= '0; scnt <= '0; closed <= 1'b0;
      sh <= '0; st <= '0; sc <= '0; rh <= '0; rt <= '0; rc <= '0;
    end else begin
      if (go) state <= BS_FULL;
      else if (m_tready) state <= BS_IDLE;
      if (go) begin
        if (q_cmd.op == OP_CLOSE) closed <= 1'b1;
        if (do_rd) rdp <= rnext(rdp, cap);
        if (do_wr) wrp <= rnext(wrp, cap);
        scnt <= scnt + (MsgAw+1)'(do_wr) - (MsgAw+1)'(do_rd);
        if (s_pop) sh <= wnext(sh);
        if (s_push) st <= wnext(st);
        sc <= sc + (WaitAw+1)'(s_push) - (WaitAw+1)'(s_pop);
        if (r_pop) rh <= wnext(rh);
        if (r_push) rt <= wnext(rt);
        rc <= rc + (WaitAw+1)'(r_push) - (WaitAw+1)'(r_pop);
      end
    end
  end
endmodule

// ----- dv/bounded_channel_with_waiters_unit_tb.sv -----
`timescale 1ns / 1ps
module bounded_channel_with_waiters_unit_tb;
  import bcw_pkg::*;

  // codes that no operation uses, the block must ignore them
  localparam logic [2:0] OP_UNK_LO = 3'd5;
  localparam logic [2:0] OP_UNK_MID = 3'd6;
  localparam logic [2:0] OP_UNK_HI = 3'd7;
  // register map
  localparam logic [2:0] CAPACITY_ADDR = 3'd0;
  localparam int PHASE_ITEMS = 110;

  typedef struct {
    logic [2:0]  op;
    logic [63:0] msg;
    logic [7:0]  vm;
    logic [15:0] hd;
    bit          fixed;
    res_t        res;
  } row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  // operation[2:0], message[66:3], waiter_vm[74:67], waiter_handle[90:75], zero fill
  logic [95:0]  s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  // ok[0], message_out[64:1], wake_valid[65], wake_vm[73:66], wake_handle[89:74],
  // wake_has_value[90], wake_value[154:91], closed_flag[155], overflow[156], zero fill
  logic [159:0] m_tdata;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [2:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  bounded_channel_with_waiters_unit dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #4 clk = ~clk;

  // shadow of the channel state
  logic [63:0] slot_shadow [MsgDepth];
  int          rd_slot, wr_slot, msgs_held;
  bit          chan_closed;
  logic [23:0] parked_tx_tags[$];
  logic [63:0] parked_tx_vals[$];
  logic [23:0] parked_rx_tags[$];
  logic [4:0]  capacity_reg;

  res_t        pending_results[$];
  int          errors;
  int          tx_idle_pct, rx_idle_pct;
  row_t        plan[$];

  function automatic int slots_usable();
    return (capacity_reg > MsgDepth) ? MsgDepth : int'(capacity_reg);
  endfunction

  // ring pointer step, wraps at the usable capacity (and at zero capacity)
  function automatic int slot_after(int p);
    return (p + 1 >= slots_usable()) ? 0 : p + 1;
  endfunction

  function automatic res_t channel_step(logic [2:0] op, logic [63:0] msg,
                                        logic [7:0] vm, logic [15:0] hd);
    res_t        r;
    logic [23:0] t;
    int          usable;
    r = '0;
    usable = slots_usable();
    case (op)
      OP_SEND: begin
        if (!chan_closed) begin
          if (parked_rx_tags.size() > 0) begin
            // straight hand-off to the oldest parked receiver
            t = parked_rx_tags.pop_front();
            r.ok = 1'b1;
            r.wake_valid = 1'b1;
            r.wake_vm = t[23:16];
            r.wake_handle = t[15:0];
            r.wake_has_value = 1'b1;
            r.wake_value = msg;
          end else if (usable > 0 && msgs_held < usable) begin
            slot_shadow[wr_slot] = msg;
            wr_slot = slot_after(wr_slot);
            msgs_held++;
            r.ok = 1'b1;
          end
        end
      end
      OP_RECV: begin
        if (msgs_held > 0) begin
          r.message_out = slot_shadow[rd_slot];
          rd_slot = slot_after(rd_slot);
          msgs_held--;
          r.ok = 1'b1;
          // refill from the oldest parked sender
          if (usable > 0 && parked_tx_tags.size() > 0) begin
            t = parked_tx_tags.pop_front();
            slot_shadow[wr_slot] = parked_tx_vals.pop_front();
            wr_slot = slot_after(wr_slot);
            msgs_held++;
            r.wake_valid = 1'b1;
            r.wake_vm = t[23:16];
            r.wake_handle = t[15:0];
          end
        end else if (parked_tx_tags.size() > 0) begin
          t = parked_tx_tags.pop_front();
          r.message_out = parked_tx_vals.pop_front();
          r.ok = 1'b1;
          r.wake_valid = 1'b1;
          r.wake_vm = t[23:16];
          r.wake_handle = t[15:0];
        end
      end
      OP_PARK_S: begin
        if (parked_tx_tags.size() < WaiterDepth) begin
          parked_tx_tags.push_back({vm, hd});
          parked_tx_vals.push_back(msg);
        end else begin
          r.overflow = 1'b1;
        end
      end
      OP_PARK_R: begin
        if (parked_rx_tags.size() < WaiterDepth) parked_rx_tags.push_back({vm, hd});
        else r.overflow = 1'b1;
      end
      OP_CLOSE: chan_closed = 1'b1;
      default: ;
    endcase
    r.closed_flag = chan_closed;
    return r;
  endfunction

  function automatic res_t flags_only(bit closed, bit ovf);
    res_t r;
    r = '0;
    r.closed_flag = closed;
    r.overflow = ovf;
    return r;
  endfunction

  function automatic row_t mk_row(logic [2:0] op, logic [63:0] msg, logic [7:0] vm,
                                  logic [15:0] hd, bit fixed, res_t res);
    row_t w;
    w.op = op;
    w.msg = msg;
    w.vm = vm;
    w.hd = hd;
    w.fixed = fixed;
    w.res = res;
    return w;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // one input transfer; called at a falling edge, returns at a falling edge
  task automatic push_op(logic [2:0] op, logic [63:0] msg, logic [7:0] vm,
                         logic [15:0] hd, bit fixed, res_t fixed_res);
    res_t predicted;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {5'b0, hd, vm, msg, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = channel_step(op, msg, vm, hd);
    pending_results.push_back(fixed ? fixed_res : predicted);
    @(negedge clk);
  endtask

  task automatic random_op();
    int          pick;
    logic [2:0]  op;
    logic [63:0] msg;
    pick = $urandom_range(99);
    if (pick < 35) op = OP_SEND;
    else if (pick < 70) op = OP_RECV;
    else if (pick < 82) op = OP_PARK_S;
    else if (pick < 94) op = OP_PARK_R;
    else op = 3'($urandom_range(OP_UNK_LO, OP_UNK_HI));
    case ($urandom_range(9))
      0: msg = '0;
      1: msg = '1;
      default: msg = {$urandom, $urandom};
    endcase
    push_op(op, msg, 8'($urandom_range(255)), 16'($urandom_range(65535)), 1'b0, '0);
  endtask

  // wait for every result, then let the two-stage pipe settle
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  // empty the ring so that a capacity change never exposes an unwritten slot
  task automatic drain_ring();
    while (msgs_held > 0) push_op(OP_RECV, '0, '0, '0, 1'b0, '0);
    settle();
  endtask

  task automatic write_capacity(logic [4:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CAPACITY_ADDR;
    pwdata <= {27'b0, value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    capacity_reg = value;
    @(negedge clk);
    // read back in the following transfer
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    check_field("prdata", 64'(prdata), 64'(value));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic walk_plan();
    foreach (plan[i]) push_op(plan[i].op, plan[i].msg, plan[i].vm, plan[i].hd,
                              plan[i].fixed, plan[i].res);
    plan.delete();
  endtask

  // receiver side stalls
  always @(negedge clk) m_tready <= ($urandom_range(99) >= rx_idle_pct);

  // result checker
  always @(posedge clk) begin
    res_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", m_tdata[63:0], '0);
      end else begin
        want = pending_results.pop_front();
        check_field("ok", 64'(m_tdata[0]), 64'(want.ok));
        check_field("message_out", m_tdata[64:1], want.message_out);
        check_field("wake_valid", 64'(m_tdata[65]), 64'(want.wake_valid));
        check_field("wake_vm", 64'(m_tdata[73:66]), 64'(want.wake_vm));
        check_field("wake_handle", 64'(m_tdata[89:74]), 64'(want.wake_handle));
        check_field("wake_has_value", 64'(m_tdata[90]), 64'(want.wake_has_value));
        check_field("wake_value", m_tdata[154:91], want.wake_value);
        check_field("closed_flag", 64'(m_tdata[155]), 64'(want.closed_flag));
        check_field("overflow", 64'(m_tdata[156]), 64'(want.overflow));
      end
    end
  end

  // hard stop for a hung handshake
  initial begin
    #3000000;
    $display("bounded_channel_with_waiters_unit_tb NOT OK");
    $finish;
  end

  initial begin
    logic [4:0] cap_list[6];
    cap_list = '{5'd16, 5'd1, 5'd31, 5'd3, 5'd0, 5'd9};
    errors = 0;
    rd_slot = 0;
    wr_slot = 0;
    msgs_held = 0;
    chan_closed = 1'b0;
    capacity_reg = '0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part, capacity still at its reset value of zero (rendezvous)
    plan.push_back(mk_row(OP_SEND, '1, '1, '1, 1'b1, flags_only(1'b0, 1'b0)));   // no taker
    plan.push_back(mk_row(OP_RECV, '0, '0, '0, 1'b1, flags_only(1'b0, 1'b0)));   // nothing there
    plan.push_back(mk_row(OP_PARK_R, '0, 8'hff, 16'hffff, 1'b1, flags_only(1'b0, 1'b0)));
    plan.push_back(mk_row(OP_SEND, '1, '0, '0, 1'b0, '0));                       // hand-off
    plan.push_back(mk_row(OP_PARK_S, '0, '0, '0, 1'b1, flags_only(1'b0, 1'b0)));
    plan.push_back(mk_row(OP_RECV, '0, '0, '0, 1'b0, '0));                       // direct take
    plan.push_back(mk_row(OP_PARK_S, 64'h8000_0000_0000_0001, 8'h5a, 16'h8001, 1'b1,
                          flags_only(1'b0, 1'b0)));
    plan.push_back(mk_row(OP_SEND, 64'h1234, '0, '0, 1'b1, flags_only(1'b0, 1'b0)));
    plan.push_back(mk_row(OP_RECV, '0, '0, '0, 1'b0, '0));
    plan.push_back(mk_row(OP_UNK_HI, '1, '1, '1, 1'b1, flags_only(1'b0, 1'b0)));
    plan.push_back(mk_row(OP_UNK_LO, '1, '1, '1, 1'b1, flags_only(1'b0, 1'b0)));
    // fill both waiter fifos, one past full each
    for (int k = 0; k <= WaiterDepth; k++)
      plan.push_back(mk_row(OP_PARK_R, '0, 8'(k), 16'(16'h00ff << k), 1'b1,
                            flags_only(1'b0, k == WaiterDepth)));
    for (int k = 0; k <= WaiterDepth; k++)
      plan.push_back(mk_row(OP_PARK_S, {$urandom, $urandom}, 8'(8'hf0 | k), 16'(k), 1'b1,
                            flags_only(1'b0, k == WaiterDepth)));
    walk_plan();
    settle();

    // random phases, one capacity each, rotating the stall pattern
    foreach (cap_list[p]) begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      drain_ring();
      write_capacity(cap_list[p]);
      case (p % 3)
        0: begin
          tx_idle_pct = 9;
          rx_idle_pct = 85;
        end
        1: begin
          tx_idle_pct = 85;
          rx_idle_pct = 9;
        end
        default: ;
      endcase
      repeat (PHASE_ITEMS) random_op();
      settle();
    end

    // closing is permanent, so it comes last
    tx_idle_pct = 0;
    plan.push_back(mk_row(OP_CLOSE, '0, '0, '0, 1'b1, flags_only(1'b1, 1'b0)));
    plan.push_back(mk_row(OP_SEND, '1, '0, '0, 1'b1, flags_only(1'b1, 1'b0)));
    plan.push_back(mk_row(OP_RECV, '0, '0, '0, 1'b0, '0));
    plan.push_back(mk_row(OP_PARK_R, '0, 8'h11, 16'h2222, 1'b0, '0));
    plan.push_back(mk_row(OP_CLOSE, '0, '0, '0, 1'b1, flags_only(1'b1, 1'b0)));
    plan.push_back(mk_row(OP_UNK_MID, '0, '0, '0, 1'b1, flags_only(1'b1, 1'b0)));
    walk_plan();
    settle();

    if (errors == 0) begin
      $display("bounded_channel_with_waiters_unit_tb OK");
    end else begin
      $display("bounded_channel_with_waiters_unit_tb NOT OK");
    end
    $finish;
  end
endmodule
